[design/telnet_console_input_filter_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the console input filter
// Build with NO_ASSERTIONS defined to drop every check.
// ----------------------------------------------------------------------------
`ifndef TELNET_CONSOLE_INPUT_FILTER_CORE_DEFINES_SVH
`define TELNET_CONSOLE_INPUT_FILTER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked outside reset only
`define TCIF_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define TCIF_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCIF_ASSERT(name, clk, rst, prop, msg)
`define TCIF_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

[design/tcif_pkg.sv]
// ----------------------------------------------------------------------------
// tcif_pkg
// Types and byte codes shared by the console input filter modules.
// ----------------------------------------------------------------------------
package tcif_pkg;

   typedef struct packed {
      logic       kind;
      logic [7:0] line_byte;
   } req_type;

   typedef struct packed {
      logic       out_kind;
      logic [7:0] out_byte;
      logic       read_valid;
      logic       last;
      logic       fifo_nonempty;
   } rsp_type;

   localparam logic KIND_LINE = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam logic [7:0] B_NUL   = 8'h00;
   localparam logic [7:0] B_LF    = 8'h0a;
   localparam logic [7:0] B_ESC   = 8'h1b;
   localparam logic [7:0] B_RC1   = 8'h1d;
   localparam logic [7:0] B_RC2   = 8'hb3;
   localparam logic [7:0] B_LBRK  = 8'h5b;
   localparam logic [7:0] B_UP    = 8'h41;
   localparam logic [7:0] B_DOWN  = 8'h42;
   localparam logic [7:0] B_RIGHT = 8'h43;
   localparam logic [7:0] B_LEFT  = 8'h44;
   localparam logic [7:0] K_UP    = 8'd16;
   localparam logic [7:0] K_DOWN  = 8'd14;
   localparam logic [7:0] K_RIGHT = 8'd6;
   localparam logic [7:0] K_LEFT  = 8'd2;

   localparam logic [7:0] T_IAC   = 8'd255;
   localparam logic [7:0] T_DONT  = 8'd254;
   localparam logic [7:0] T_DO    = 8'd253;
   localparam logic [7:0] T_WONT  = 8'd252;
   localparam logic [7:0] T_WILL  = 8'd251;
   localparam logic [7:0] T_SB    = 8'd250;
   localparam logic [7:0] T_SE    = 8'd240;
   localparam logic [7:0] T_TTYPE = 8'd24;
   localparam logic [7:0] T_SEND  = 8'd1;
   localparam logic [7:0] T_IS    = 8'd0;

   localparam int          TTYPE_LEN  = 6;
   localparam logic [2:0]  TTYPE_LAST = 3'(TTYPE_LEN - 1);

   // work queue between parser and FIFO engine
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = 2;

   typedef enum logic [1:0] {
      OP_PUSH,
      OP_READ,
      OP_TTYPE
   } op_type;

   typedef struct packed {
      op_type          op;
      logic [1:0]      cnt;   // bytes to store for OP_PUSH, 1 to 3
      logic [2:0][7:0] data;  // data[0] is stored first
   } work_type;

   // IAC SB TTYPE SEND IAC SE
   function automatic logic [7:0] ttype_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = T_IAC;
         3'd1:    b = T_SB;
         3'd2:    b = T_TTYPE;
         3'd3:    b = T_SEND;
         3'd4:    b = T_IAC;
         default: b = T_SE;
      endcase
      return b;
   endfunction

endpackage

[design/telnet_console_input_filter_core.sv]
// ----------------------------------------------------------------------------
// telnet_console_input_filter_core
// Console input filter: telnet IAC stripping, VT100 arrow mapping, ring FIFO.
// Items enter one per cycle into a 4-entry work queue until it fills.
// The FIFO engine pops an entry when idle, then stores or drops its bytes, serves
// a read or sends the terminal-type request, reads and that request waiting on result
// stalls; a read reply passes the RAM read and result registers, on an empty FIFO only the latter.
// Synchronous reset clears parser, indices, queue and result stage; no RAM clear.
// ----------------------------------------------------------------------------
module telnet_console_input_filter_core #(
   parameter int FIFO_DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tcif_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tcif_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);

   logic               q_push;
   logic               q_full;
   logic               q_pop;
   logic               q_valid;
   tcif_pkg::work_type q_entry;
   tcif_pkg::work_type q_head;

   assign csr_ready = 1'b1;

   tcif_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .csr_valid(csr_valid),
      .csr_data (csr_data),
      .q_push   (q_push),
      .q_entry  (q_entry),
      .q_full   (q_full)
   );

   tcif_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_entry(q_entry),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .head_valid(q_valid)
   );

   tcif_back #(
      .FIFO_DEPTH(FIFO_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_head   (q_head),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

[design/tcif_ram.sv]
// ----------------------------------------------------------------------------
// tcif_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module tcif_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/tcif_queue.sv]
// ----------------------------------------------------------------------------
// tcif_queue
// Small work queue that decouples the parser from the FIFO engine.
// ----------------------------------------------------------------------------
`include "telnet_console_input_filter_core_defines.svh"

module tcif_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tcif_pkg::work_type push_entry,
   output logic               full,
   input  logic               pop,
   output tcif_pkg::work_type head,
   output logic               head_valid
);

   tcif_pkg::work_type        entry_ff [tcif_pkg::Q_DEPTH];
   logic [tcif_pkg::Q_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tcif_pkg::Q_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tcif_pkg::Q_AW:0]   count_ff, count_in;

   assign full       = (count_ff == (tcif_pkg::Q_AW + 1)'(tcif_pkg::Q_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `TCIF_ASSERT(a_no_push_full, clock, reset, push |-> !full, "push into full work queue")
   `TCIF_ASSERT(a_no_pop_empty, clock, reset, pop |-> head_valid, "pop from empty work queue")
   `TCIF_ASSERT(a_count_bound, clock, reset, count_ff <= (tcif_pkg::Q_AW + 1)'(tcif_pkg::Q_DEPTH), "work queue count overflow")

endmodule

[design/tcif_front.sv]
// ----------------------------------------------------------------------------
// tcif_front
// Accepts requests, holds the terminal-support register and the escape /
// telnet parser, and turns the items it keeps into work entries for the back end.
// ----------------------------------------------------------------------------
module tcif_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tcif_pkg::req_type  req_data,
   input  logic               csr_valid,
   input  logic               csr_data,
   output logic               q_push,
   output tcif_pkg::work_type q_entry,
   input  logic               q_full
);

   typedef enum logic [3:0] {
      PS_TEXT,
      PS_ESC,
      PS_CSI,
      PS_REMOTE,
      PS_TEL,
      PS_TEL_OPT,
      PS_SB_OPT,
      PS_SB_QUAL,
      PS_SB_NAME,
      PS_SKIP
   } parse_type;

   parse_type  state_ff, state_in;
   logic [7:0] cmd_ff, cmd_in;
   logic [7:0] opt_ff, opt_in;
   logic       term_ff;
   logic       accept;
   logic [7:0] c;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign c         = req_data.line_byte;

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      opt_in   = opt_ff;
      q_push   = 1'b0;
      q_entry  = '{op: tcif_pkg::OP_PUSH, cnt: 2'd1, data: '0};
      q_entry.data[0] = c;

      if (accept) begin
         if (req_data.kind == tcif_pkg::KIND_READ) begin
            q_push     = 1'b1;
            q_entry.op = tcif_pkg::OP_READ;
         end else if (!term_ff) begin
            // raw mode: parser state held
            q_push = 1'b1;
         end else begin
            unique case (state_ff)
               PS_TEXT: begin
                  if (c == tcif_pkg::B_ESC) begin
                     state_in = PS_ESC;
                  end else if (c == tcif_pkg::B_RC1 || c == tcif_pkg::B_RC2) begin
                     state_in = PS_REMOTE;
                  end else if (c == tcif_pkg::T_IAC) begin
                     state_in = PS_TEL;
                  end else if (c != tcif_pkg::B_NUL && c != tcif_pkg::B_LF) begin
                     q_push = 1'b1;
                  end
               end
               PS_ESC: begin
                  if (c == tcif_pkg::B_LBRK) begin
                     state_in = PS_CSI;
                  end else begin
                     q_push          = 1'b1;
                     q_entry.cnt     = 2'd2;
                     q_entry.data[0] = tcif_pkg::B_ESC;
                     q_entry.data[1] = c;
                     state_in        = PS_TEXT;
                  end
               end
               PS_CSI: begin
                  q_push   = 1'b1;
                  state_in = PS_TEXT;
                  case (c)
                     tcif_pkg::B_UP:    q_entry.data[0] = tcif_pkg::K_UP;
                     tcif_pkg::B_DOWN:  q_entry.data[0] = tcif_pkg::K_DOWN;
                     tcif_pkg::B_RIGHT: q_entry.data[0] = tcif_pkg::K_RIGHT;
                     tcif_pkg::B_LEFT:  q_entry.data[0] = tcif_pkg::K_LEFT;
                     default: begin
                        // unknown sequence is stored as ESC '[' c
                        q_entry.cnt     = 2'd3;
                        q_entry.data[0] = tcif_pkg::B_ESC;
                        q_entry.data[1] = tcif_pkg::B_LBRK;
                        q_entry.data[2] = c;
                     end
                  endcase
               end
               PS_REMOTE: begin
                  state_in = PS_TEXT;
               end
               PS_TEL: begin
                  cmd_in = c;
                  if (c inside {tcif_pkg::T_WILL, tcif_pkg::T_WONT,
                                tcif_pkg::T_DO, tcif_pkg::T_DONT}) begin
                     state_in = PS_TEL_OPT;
                  end else if (c == tcif_pkg::T_SB) begin
                     state_in = PS_SB_OPT;
                  end else begin
                     q_push   = (c == tcif_pkg::T_IAC);
                     state_in = PS_TEXT;
                  end
               end
               PS_TEL_OPT: begin
                  opt_in     = c;
                  state_in   = PS_TEXT;
                  q_push     = (cmd_ff == tcif_pkg::T_WILL) && (c == tcif_pkg::T_TTYPE);
                  q_entry.op = tcif_pkg::OP_TTYPE;
               end
               PS_SB_OPT: begin
                  opt_in   = c;
                  state_in = PS_SB_QUAL;
               end
               PS_SB_QUAL: begin
                  state_in = (opt_ff == tcif_pkg::T_TTYPE && c == tcif_pkg::T_IS) ?
                             PS_SB_NAME : PS_SKIP;
               end
               PS_SB_NAME: begin
                  state_in = PS_SKIP;
               end
               PS_SKIP: begin
                  if (c == tcif_pkg::T_IAC) begin
                     state_in = PS_TEL;
                  end
               end
               default: begin
                  state_in = PS_TEXT;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PS_TEXT;
         cmd_ff   <= '0;
         opt_ff   <= '0;
         term_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cmd_ff   <= cmd_in;
         opt_ff   <= opt_in;
         if (csr_valid) begin
            term_ff <= csr_data;
         end
      end
   end

endmodule

[design/tcif_back.sv]
// ----------------------------------------------------------------------------
// tcif_back
// Executes work entries: stores bytes in the ring FIFO, serves reads and
// sends the terminal-type request, through a registered result stage.
// ----------------------------------------------------------------------------
`include "telnet_console_input_filter_core_defines.svh"

module tcif_back #(
   parameter int FIFO_DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  tcif_pkg::work_type q_head,
   input  logic               q_valid,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tcif_pkg::rsp_type  rsp_data
);

   localparam int AW = $clog2(FIFO_DEPTH);

   typedef enum logic [2:0] {
      B_IDLE,
      B_PUSH,
      B_READ,
      B_RDATA,
      B_TTYPE
   } back_type;

   back_type           state_ff, state_in;
   tcif_pkg::work_type work_ff, work_in;
   logic [2:0]         idx_ff, idx_in;
   logic [AW-1:0]      wr_ff, wr_in;
   logic [AW-1:0]      rd_ff, rd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   tcif_pkg::rsp_type  rsp_data_ff, rsp_data_in;
   logic [AW-1:0]      wr_next, rd_next;
   logic               slot_free;
   logic               ram_we, ram_re;
   logic [7:0]         ram_q;

   assign wr_next   = (wr_ff == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
   assign rd_next   = (rd_ff == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      idx_in       = idx_ff;
      wr_in        = wr_ff;
      rd_in        = rd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;

      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               work_in = q_head;
               idx_in  = '0;
               case (q_head.op)
                  tcif_pkg::OP_PUSH:  state_in = B_PUSH;
                  tcif_pkg::OP_READ:  state_in = B_READ;
                  tcif_pkg::OP_TTYPE: state_in = B_TTYPE;
                  default:            state_in = B_IDLE;
               endcase
            end
         end
         B_PUSH: begin
            // one byte a cycle, dropped silently when full
            if (wr_next != rd_ff) begin
               ram_we = 1'b1;
               wr_in  = wr_next;
            end
            if (idx_ff[1:0] == work_ff.cnt - 2'd1) begin
               state_in = B_IDLE;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
         B_READ: begin
            if (slot_free) begin
               if (rd_ff == wr_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{out_kind: 1'b1, out_byte: 8'd0, read_valid: 1'b0,
                                   last: 1'b1, fifo_nonempty: 1'b0};
                  state_in     = B_IDLE;
               end else begin
                  ram_re   = 1'b1;
                  rd_in    = rd_next;
                  state_in = B_RDATA;
               end
            end
         end
         B_RDATA: begin
            // slot was freed on entry here
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{out_kind: 1'b1, out_byte: ram_q, read_valid: 1'b1,
                             last: 1'b1, fifo_nonempty: (rd_ff != wr_ff)};
            state_in     = B_IDLE;
         end
         B_TTYPE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_kind: 1'b0, out_byte: tcif_pkg::ttype_byte(idx_ff),
                                read_valid: 1'b0, last: (idx_ff == tcif_pkg::TTYPE_LAST),
                                fifo_nonempty: (rd_ff != wr_ff)};
               if (idx_ff == tcif_pkg::TTYPE_LAST) begin
                  state_in = B_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         idx_ff       <= '0;
         wr_ff        <= '0;
         rd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         wr_ff        <= wr_in;
         rd_ff        <= rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      work_ff     <= work_in;
      rsp_data_ff <= rsp_data_in;
   end

   tcif_ram #(
      .WIDTH(8),
      .DEPTH(FIFO_DEPTH)
   ) u_fifo_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(wr_ff),
      .wr_data(work_ff.data[idx_ff[1:0]]),
      .rd_en  (ram_re),
      .rd_addr(rd_ff),
      .rd_data(ram_q)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `TCIF_ASSERT(a_rdata_slot_empty, clock, reset, (state_ff == B_RDATA) |-> !rsp_valid_ff, "read data arrives with result stage occupied")
   `TCIF_ASSERT(a_no_write_full, clock, reset, ram_we |-> (wr_next != rd_ff), "FIFO write while full")
   `TCIF_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid_ff, "result valid after reset")

endmodule
